### hw/rtl/gtpv2c_imsi_shard_steering_core_assert.svh
// Assertion macros for the GTPv2-C IMSI shard steering block.
// Used by the top level; needs nothing else.
`ifndef GTPV2C_IMSI_SHARD_STEERING_CORE_ASSERT_SVH
`define GTPV2C_IMSI_SHARD_STEERING_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GTPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtpsteer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GTPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtpsteer: next-cycle check failed");

`endif

### hw/rtl/gtpsteer_pkg.sv
// Shared types and constants of the GTPv2-C IMSI shard steering block.
// No dependencies; used by the interfaces, the step unit and the top level.
package gtpsteer_pkg;

    localparam int BYTE_W             = 8;
    localparam int POS_W              = 16;
    localparam int HASH_W             = 32;
    localparam int WORKER_W           = 8;
    localparam int NIB_W              = 4;
    localparam int STATUS_W           = 2;
    localparam int APB_DATA_W         = 32;
    localparam int PADDR_W            = 2;
    localparam int MAX_IMSI_BYTES_DEF = 8;
    localparam int BIT_CNT_W          = $clog2(HASH_W);

    localparam logic [HASH_W-1:0]   HASH_SEED     = 32'd5381;
    localparam logic [BYTE_W-1:0]   IMSI_TYPE     = 8'd1;
    localparam logic [BYTE_W-1:0]   ASCII_ZERO    = 8'h30;
    localparam logic [NIB_W-1:0]    NIB_FILLER    = 4'hf;
    localparam logic [NIB_W-1:0]    INSTANCE_ZERO = 4'h0;
    localparam int                  TEID_FLAG_BIT = 3;
    localparam logic [POS_W-1:0]    SHORT_HDR     = 16'd8;
    localparam logic [POS_W-1:0]    LONG_HDR      = 16'd12;
    localparam logic [PADDR_W-1:0]  REG_WORKER_COUNT = 2'd0;
    localparam logic [WORKER_W-1:0] WORKER_RESET  = 8'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND   = 2'd0,
        ST_SHORT   = 2'd1,
        ST_NO_IMSI = 2'd2
    } t_status;

    typedef enum logic {
        STEP_HASH = 1'b0,
        STEP_MOD  = 1'b1
    } t_step_op;

    typedef struct packed {
        t_step_op              op;
        logic [HASH_W-1:0]     hash;
        logic [NIB_W-1:0]      nib;
        logic [WORKER_W-1:0]   rem;
        logic                  bit_in;
        logic [WORKER_W-1:0]   divisor;
    } t_step_req;

    typedef struct packed {
        logic [HASH_W-1:0]     hash_next;
        logic [WORKER_W-1:0]   rem_next;
    } t_step_rsp;

endpackage

### hw/rtl/gtpsteer_if.sv
// Handshake channels of the steering block: message bytes in, results out.
// Depends on gtpsteer_pkg for the field widths.
interface gtpsteer_msg_if;
    logic                              valid;
    logic                              ready;
    logic [gtpsteer_pkg::BYTE_W-1:0]   data_byte;
    logic                              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gtpsteer_res_if;
    logic                              valid;
    logic                              ready;
    logic [gtpsteer_pkg::STATUS_W-1:0] status;
    logic [gtpsteer_pkg::WORKER_W-1:0] shard_index;

    modport source (output valid, output status, output shard_index, input ready);
    modport sink   (input valid, input status, input shard_index, output ready);
endinterface

### hw/rtl/gtpv2c_imsi_shard_steering_core.sv
// Top level of the GTPv2-C IMSI shard steering block: element walk, sequencer,
// APB register and result register. Depends on gtpsteer_pkg, the channel
// interfaces and gtpsteer_step_unit.

// The block takes one message byte per cycle while walking the header and the
// elements, but holds the input off while it is busy with a byte named below.
// A value byte among the first MAX_IMSI_BYTES bytes of the IMSI element has
// its two TBCD digits go one after the other through the single shared
// hash/remainder unit (S_NIB0, S_NIB1), and a closing step (S_POST) follows.
// The byte that ends the IMSI element and the byte marked last also pass
// through that closing step, which commits the hash and, for the byte marked
// last, settles the status. Then, when an IMSI was found, the bit-serial
// remainder by worker_count runs in S_MOD, and S_OUT loads the result
// register, where the result waits while the next message starts; a further
// result is held back until the previous one is taken. worker_count sits at
// APB address 0 and reads back; a value of 0 acts as 1.
`include "gtpv2c_imsi_shard_steering_core_assert.svh"

module gtpv2c_imsi_shard_steering_core #(
    parameter int MAX_IMSI_BYTES = gtpsteer_pkg::MAX_IMSI_BYTES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    gtpsteer_msg_if.sink                           i_msg,
    gtpsteer_res_if.source                         o_res,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [gtpsteer_pkg::PADDR_W-1:0]       paddr,
    input  logic [gtpsteer_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [gtpsteer_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    localparam int IDX_W = $clog2(MAX_IMSI_BYTES + 1);
    localparam int PW    = gtpsteer_pkg::POS_W;
    localparam int HW    = gtpsteer_pkg::HASH_W;
    localparam int WW    = gtpsteer_pkg::WORKER_W;
    localparam int BW    = gtpsteer_pkg::BYTE_W;
    localparam int CW    = gtpsteer_pkg::BIT_CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_NIB0, S_NIB1, S_POST, S_MOD, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_HEADER, PH_TYPE, PH_LEN_HI, PH_LEN_LO, PH_INST, PH_IMSI, PH_SKIP, PH_DONE
    } t_phase;

    t_state                 r_state, n_state;
    t_phase                 r_phase, n_phase;
    logic [PW-1:0]          r_pos, n_pos;
    logic                   r_long_hdr, n_long_hdr;
    logic [BW-1:0]          r_elem_type, n_elem_type;
    logic [PW-1:0]          r_elem_len, n_elem_len;
    logic [PW-1:0]          r_left, n_left;
    logic [IDX_W-1:0]       r_imsi_cnt, n_imsi_cnt;
    logic [HW-1:0]          r_hash, n_hash;
    logic                   r_filler, n_filler;
    logic                   r_found, n_found;
    logic [HW-1:0]          r_committed, n_committed;
    logic [BW-1:0]          r_byte, n_byte;
    logic                   r_commit, n_commit;
    logic                   r_last, n_last;
    logic [WW-1:0]          r_rem, n_rem;
    logic [HW-1:0]          r_dividend, n_dividend;
    logic [CW-1:0]          r_bit_cnt, n_bit_cnt;
    logic [WW-1:0]          r_divisor, n_divisor;
    gtpsteer_pkg::t_status  r_status, n_status;
    logic                   r_out_valid, n_out_valid;
    gtpsteer_pkg::t_status  r_out_status, n_out_status;
    logic [WW-1:0]          r_out_index, n_out_index;
    logic [WW-1:0]          r_worker_count, n_worker_count;

    gtpsteer_pkg::t_step_req step_req;
    gtpsteer_pkg::t_step_rsp step_rsp;

    logic           in_fire;
    logic           hdr_long;
    logic           go_nib;
    logic [3:0]     nib;
    logic [PW-1:0]  hdr_len;
    logic           cfg_write;

    gtpsteer_step_unit u_step (
        .i_req (step_req),
        .o_rsp (step_rsp)
    );

    assign in_fire   = i_msg.valid && i_msg.ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign hdr_len   = r_long_hdr ? gtpsteer_pkg::LONG_HDR : gtpsteer_pkg::SHORT_HDR;
    assign nib       = (r_state == S_NIB0) ? r_byte[3:0] : r_byte[7:4];

    assign i_msg.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.shard_index = r_out_index;

    assign pready = 1'b1;
    assign prdata = (paddr == gtpsteer_pkg::REG_WORKER_COUNT)
                  ? {{(gtpsteer_pkg::APB_DATA_W-WW){1'b0}}, r_worker_count} : '0;

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_long_hdr     = r_long_hdr;
        n_elem_type    = r_elem_type;
        n_elem_len     = r_elem_len;
        n_left         = r_left;
        n_imsi_cnt     = r_imsi_cnt;
        n_hash         = r_hash;
        n_filler       = r_filler;
        n_found        = r_found;
        n_committed    = r_committed;
        n_byte         = r_byte;
        n_commit       = r_commit;
        n_last         = r_last;
        n_rem          = r_rem;
        n_dividend     = r_dividend;
        n_bit_cnt      = r_bit_cnt;
        n_divisor      = r_divisor;
        n_status       = r_status;
        n_out_valid    = r_out_valid;
        n_out_status   = r_out_status;
        n_out_index    = r_out_index;
        n_worker_count = cfg_write && (paddr == gtpsteer_pkg::REG_WORKER_COUNT)
                       ? pwdata[WW-1:0] : r_worker_count;
        hdr_long       = r_long_hdr;
        go_nib         = 1'b0;

        step_req         = '0;
        step_req.op      = gtpsteer_pkg::STEP_HASH;
        step_req.hash    = r_hash;
        step_req.nib     = nib;
        step_req.rem     = r_rem;
        step_req.bit_in  = r_dividend[HW-1];
        step_req.divisor = r_divisor;

        // The result register empties when the sink takes the item.
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_byte   = i_msg.data_byte;
                    n_last   = i_msg.last_byte;
                    n_commit = 1'b0;
                    case (r_phase)
                        PH_HEADER: begin
                            if (r_pos == '0) begin
                                hdr_long = i_msg.data_byte[gtpsteer_pkg::TEID_FLAG_BIT];
                            end
                            n_long_hdr = hdr_long;
                            if (r_pos >= (hdr_long ? gtpsteer_pkg::LONG_HDR - PW'(1)
                                                   : gtpsteer_pkg::SHORT_HDR - PW'(1))) begin
                                n_phase = PH_TYPE;
                            end
                        end
                        PH_TYPE: begin
                            n_elem_type = i_msg.data_byte;
                            n_phase     = PH_LEN_HI;
                        end
                        PH_LEN_HI: begin
                            n_elem_len = {i_msg.data_byte, r_elem_len[BW-1:0]};
                            n_phase    = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            n_elem_len = {r_elem_len[PW-1:BW], i_msg.data_byte};
                            n_phase    = PH_INST;
                        end
                        PH_INST: begin
                            n_left = r_elem_len;
                            if (r_elem_len == '0) begin
                                n_phase = PH_TYPE;
                            end else if (r_elem_type == gtpsteer_pkg::IMSI_TYPE &&
                                         i_msg.data_byte[3:0] == gtpsteer_pkg::INSTANCE_ZERO)
                            begin
                                n_hash     = gtpsteer_pkg::HASH_SEED;
                                n_filler   = 1'b0;
                                n_imsi_cnt = '0;
                                n_phase    = PH_IMSI;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                        PH_IMSI: begin
                            if (r_imsi_cnt < IDX_W'(MAX_IMSI_BYTES)) begin
                                go_nib     = 1'b1;
                                n_imsi_cnt = r_imsi_cnt + IDX_W'(1);
                            end
                            n_left = r_left - PW'(1);
                            if (r_left == PW'(1)) begin
                                n_commit = 1'b1;
                                n_phase  = PH_DONE;
                            end
                        end
                        PH_SKIP: begin
                            n_left = r_left - PW'(1);
                            if (r_left == PW'(1)) begin
                                n_phase = PH_TYPE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (r_pos != '1) begin
                        n_pos = r_pos + PW'(1);
                    end
                    if (go_nib) begin
                        n_state = S_NIB0;
                    end else if (n_commit || i_msg.last_byte) begin
                        n_state = S_POST;
                    end
                end
            end
            S_NIB0, S_NIB1: begin
                // An F nibble ends the digit string for the rest of the element.
                if (!r_filler) begin
                    if (nib == gtpsteer_pkg::NIB_FILLER) begin
                        n_filler = 1'b1;
                    end else begin
                        n_hash = step_rsp.hash_next;
                    end
                end
                n_state = (r_state == S_NIB0) ? S_NIB1 : S_POST;
            end
            S_POST: begin
                if (r_commit) begin
                    n_committed = r_hash;
                    n_found     = 1'b1;
                    n_commit    = 1'b0;
                end
                if (r_last) begin
                    n_rem      = '0;
                    n_bit_cnt  = '0;
                    n_divisor  = (r_worker_count == '0) ? WW'(1) : r_worker_count;
                    n_dividend = r_commit ? r_hash : r_committed;
                    if (r_pos < hdr_len) begin
                        n_status = gtpsteer_pkg::ST_SHORT;
                        n_state  = S_OUT;
                    end else if (r_found || r_commit) begin
                        n_status = gtpsteer_pkg::ST_FOUND;
                        n_state  = S_MOD;
                    end else begin
                        n_status = gtpsteer_pkg::ST_NO_IMSI;
                        n_state  = S_OUT;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MOD: begin
                step_req.op = gtpsteer_pkg::STEP_MOD;
                n_rem       = step_rsp.rem_next;
                n_dividend  = r_dividend << 1;
                n_bit_cnt   = r_bit_cnt + CW'(1);
                if (r_bit_cnt == CW'(HW - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_index  = r_rem;
                    n_pos        = '0;
                    n_long_hdr   = 1'b0;
                    n_phase      = PH_HEADER;
                    n_elem_type  = '0;
                    n_elem_len   = '0;
                    n_left       = '0;
                    n_imsi_cnt   = '0;
                    n_hash       = gtpsteer_pkg::HASH_SEED;
                    n_filler     = 1'b0;
                    n_found      = 1'b0;
                    n_committed  = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase        <= PH_HEADER;
            r_pos          <= '0;
            r_long_hdr     <= 1'b0;
            r_elem_type    <= '0;
            r_elem_len     <= '0;
            r_left         <= '0;
            r_imsi_cnt     <= '0;
            r_hash         <= gtpsteer_pkg::HASH_SEED;
            r_filler       <= 1'b0;
            r_found        <= 1'b0;
            r_committed    <= '0;
            r_commit       <= 1'b0;
            r_last         <= 1'b0;
            r_rem          <= '0;
            r_bit_cnt      <= '0;
            r_divisor      <= WW'(1);
            r_status       <= gtpsteer_pkg::ST_NO_IMSI;
            r_out_valid    <= 1'b0;
            r_out_status   <= gtpsteer_pkg::ST_NO_IMSI;
            r_out_index    <= '0;
            r_worker_count <= gtpsteer_pkg::WORKER_RESET;
        end else begin
            r_state        <= n_state;
            r_phase        <= n_phase;
            r_pos          <= n_pos;
            r_long_hdr     <= n_long_hdr;
            r_elem_type    <= n_elem_type;
            r_elem_len     <= n_elem_len;
            r_left         <= n_left;
            r_imsi_cnt     <= n_imsi_cnt;
            r_hash         <= n_hash;
            r_filler       <= n_filler;
            r_found        <= n_found;
            r_committed    <= n_committed;
            r_commit       <= n_commit;
            r_last         <= n_last;
            r_rem          <= n_rem;
            r_bit_cnt      <= n_bit_cnt;
            r_divisor      <= n_divisor;
            r_status       <= n_status;
            r_out_valid    <= n_out_valid;
            r_out_status   <= n_out_status;
            r_out_index    <= n_out_index;
            r_worker_count <= n_worker_count;
        end
        r_byte     <= n_byte;
        r_dividend <= n_dividend;
    end

    // The remainder walk always ends in the result stage.
    `GTPS_ASSERT_NEXT(a_mod_exit, i_clk, i_rst_n, r_state == S_MOD, r_state == S_MOD || r_state == S_OUT)
    // The partial remainder stays below the divisor throughout the walk.
    `GTPS_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, r_state == S_MOD, r_rem < r_divisor)
    // Only a found IMSI carries a non-zero shard index.
    `GTPS_ASSERT_IMP(a_idx_zero, i_clk, i_rst_n, r_out_valid && r_out_status != gtpsteer_pkg::ST_FOUND, r_out_index == '0)
    // The last byte of a message always starts the result sequence.
    `GTPS_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, in_fire && i_msg.last_byte, r_state != S_IDLE)

endmodule

### hw/rtl/gtpsteer_step_unit.sv
// Shared arithmetic step: one djb2 hash digit or one restoring-remainder bit.
// Depends on gtpsteer_pkg for the request and response structs.
module gtpsteer_step_unit (
    input  gtpsteer_pkg::t_step_req i_req,
    output gtpsteer_pkg::t_step_rsp o_rsp
);

    localparam int HW = gtpsteer_pkg::HASH_W;
    localparam int WW = gtpsteer_pkg::WORKER_W;

    logic [HW-1:0] hash_step;
    logic [WW:0]   shifted;
    logic [WW+1:0] trial;

    // h * 33 + ('0' + digit)
    assign hash_step = (i_req.hash << 5) + i_req.hash
                     + HW'(gtpsteer_pkg::ASCII_ZERO) + HW'(i_req.nib);

    // Bring in the next dividend bit and subtract the divisor if it fits.
    assign shifted = {i_req.rem, i_req.bit_in};
    assign trial   = {1'b0, shifted} - {2'b00, i_req.divisor};

    always_comb begin
        o_rsp = '0;
        case (i_req.op)
            gtpsteer_pkg::STEP_HASH: begin
                o_rsp.hash_next = hash_step;
                o_rsp.rem_next  = i_req.rem;
            end
            gtpsteer_pkg::STEP_MOD: begin
                o_rsp.hash_next = i_req.hash;
                o_rsp.rem_next  = trial[WW+1] ? shifted[WW-1:0] : trial[WW-1:0];
            end
            default: begin
                o_rsp.hash_next = i_req.hash;
                o_rsp.rem_next  = i_req.rem;
            end
        endcase
    end

endmodule

### test/gtpv2c_imsi_shard_steering_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the GTPv2-C IMSI shard steering block.
// Streams messages byte by byte, predicts each status and shard index, and
// compares them with the block's results. Needs gtpsteer_pkg and the channel interfaces.
module gtpv2c_imsi_shard_steering_core_tb;

    localparam int IMSI_BYTES_HASHED = gtpsteer_pkg::MAX_IMSI_BYTES_DEF;
    localparam int DRAIN_CYCLES      = 80;
    localparam int DRAIN_LIMIT       = 5000;
    localparam int RANDOM_BYTES      = 1250;
    localparam int RANDOM_PHASES     = 5;
    localparam int TIMEOUT_CYCLES    = 800_000;
    localparam int REPORT_LIMIT      = 10;

    typedef enum logic [2:0] {
        WALK_HEADER,
        WALK_TYPE,
        WALK_LEN_HI,
        WALK_LEN_LO,
        WALK_INST,
        WALK_IMSI,
        WALK_SKIP,
        WALK_DONE
    } t_walk_phase;

    typedef struct packed {
        gtpsteer_pkg::t_status             status;
        logic [gtpsteer_pkg::WORKER_W-1:0] shard_index;
    } t_steer_result;

    // Tracks the element walk of the current message and holds the results
    // that the block owes us, oldest first.
    class shard_tracker;
        logic [gtpsteer_pkg::WORKER_W-1:0] workers;
        logic [gtpsteer_pkg::POS_W-1:0]    pos;
        logic [gtpsteer_pkg::POS_W-1:0]    hdr_len;
        t_walk_phase                       phase;
        logic [gtpsteer_pkg::BYTE_W-1:0]   ie_type;
        logic [gtpsteer_pkg::POS_W-1:0]    ie_len;
        logic [gtpsteer_pkg::POS_W-1:0]    left;
        logic [gtpsteer_pkg::HASH_W-1:0]   hash;
        bit                                filler;
        bit                                found;
        logic [gtpsteer_pkg::HASH_W-1:0]   committed;
        t_steer_result                     expected_steering[$];
        int                                fail_count;

        function new();
            workers = gtpsteer_pkg::WORKER_RESET;
            fail_count = 0;
            clear_message();
        endfunction

        function void clear_message();
            pos = '0;
            hdr_len = gtpsteer_pkg::SHORT_HDR;
            phase = WALK_HEADER;
            ie_type = '0;
            ie_len = '0;
            left = '0;
            hash = gtpsteer_pkg::HASH_SEED;
            filler = 1'b0;
            found = 1'b0;
            committed = '0;
        endfunction

        function void add_digit(logic [gtpsteer_pkg::NIB_W-1:0] nib);
            if (!filler) begin
                if (nib == gtpsteer_pkg::NIB_FILLER) begin
                    filler = 1'b1;
                end else begin
                    hash = hash * 32'd33 + gtpsteer_pkg::ASCII_ZERO + nib;
                end
            end
        endfunction

        function void take_byte(logic [gtpsteer_pkg::BYTE_W-1:0] b, logic is_last);
            int unsigned                       idx;
            t_steer_result                     r;
            logic [gtpsteer_pkg::WORKER_W-1:0] div;
            case (phase)
                WALK_HEADER: begin
                    if (pos == 0) begin
                        hdr_len = b[gtpsteer_pkg::TEID_FLAG_BIT] ? gtpsteer_pkg::LONG_HDR
                                                                 : gtpsteer_pkg::SHORT_HDR;
                    end
                    if (32'(pos) + 1 >= 32'(hdr_len)) phase = WALK_TYPE;
                end
                WALK_TYPE: begin
                    ie_type = b;
                    phase = WALK_LEN_HI;
                end
                WALK_LEN_HI: begin
                    ie_len = {b, 8'h00};
                    phase = WALK_LEN_LO;
                end
                WALK_LEN_LO: begin
                    ie_len[7:0] = b;
                    phase = WALK_INST;
                end
                WALK_INST: begin
                    left = ie_len;
                    if (ie_len == 0) begin
                        phase = WALK_TYPE;
                    end else if (ie_type == gtpsteer_pkg::IMSI_TYPE &&
                                 b[gtpsteer_pkg::NIB_W-1:0] == gtpsteer_pkg::INSTANCE_ZERO) begin
                        hash = gtpsteer_pkg::HASH_SEED;
                        filler = 1'b0;
                        phase = WALK_IMSI;
                    end else begin
                        phase = WALK_SKIP;
                    end
                end
                WALK_IMSI: begin
                    idx = 32'(ie_len) - 32'(left);
                    if (idx < IMSI_BYTES_HASHED) begin
                        add_digit(b[3:0]);
                        add_digit(b[7:4]);
                    end
                    left = left - 1'b1;
                    // The hash only counts once the whole value is inside the message.
                    if (left == 0) begin
                        committed = hash;
                        found = 1'b1;
                        phase = WALK_DONE;
                    end
                end
                WALK_SKIP: begin
                    left = left - 1'b1;
                    if (left == 0) phase = WALK_TYPE;
                end
                default: ;
            endcase
            if (pos != {gtpsteer_pkg::POS_W{1'b1}}) pos = pos + 1'b1;
            if (is_last) begin
                if (pos < hdr_len) begin
                    r.status = gtpsteer_pkg::ST_SHORT;
                    r.shard_index = '0;
                end else if (found) begin
                    div = (workers == 0) ? gtpsteer_pkg::WORKER_W'(1) : workers;
                    r.status = gtpsteer_pkg::ST_FOUND;
                    r.shard_index = gtpsteer_pkg::WORKER_W'(committed % div);
                end else begin
                    r.status = gtpsteer_pkg::ST_NO_IMSI;
                    r.shard_index = '0;
                end
                expected_steering.push_back(r);
                clear_message();
            end
        endfunction

        function void note_failure(string what);
            fail_count++;
            if (fail_count <= REPORT_LIMIT) $display("%0t: mismatch: %s", $time, what);
        endfunction

        function void check_result(logic [gtpsteer_pkg::STATUS_W-1:0] st,
                                   logic [gtpsteer_pkg::WORKER_W-1:0] sh);
            t_steer_result want;
            if (expected_steering.size() == 0) begin
                note_failure($sformatf("unexpected result: status %0d shard %0d", st, sh));
            end else begin
                want = expected_steering.pop_front();
                if (st !== want.status || sh !== want.shard_index) begin
                    note_failure($sformatf("expected status %0d shard %0d, got status %0d shard %0d",
                                           want.status, want.shard_index, st, sh));
                end
            end
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [gtpsteer_pkg::PADDR_W-1:0]    paddr;
    logic [gtpsteer_pkg::APB_DATA_W-1:0] pwdata;
    logic [gtpsteer_pkg::APB_DATA_W-1:0] prdata;
    logic                                pready;

    gtpsteer_msg_if msg ();
    gtpsteer_res_if res ();

    gtpv2c_imsi_shard_steering_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    shard_tracker tracker = new();

    logic [gtpsteer_pkg::BYTE_W-1:0] msg_q[$];
    int                              stall_left = 0;
    int                              ready_pick;
    bit                              ready_calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (msg.valid && msg.ready) tracker.take_byte(msg.data_byte, msg.last_byte);
            if (res.valid && res.ready) tracker.check_result(res.status, res.shard_index);
        end
    end

    // Result side back-pressure: mostly short stalls, a few long ones, and
    // stretches where ready simply stays high.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) ready_calm = !ready_calm;
        if (stall_left > 0) begin
            stall_left--;
            res.ready <= 1'b0;
        end else if (ready_calm) begin
            res.ready <= 1'b1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 4) begin
                stall_left = $urandom_range(10, 50);
                res.ready <= 1'b0;
            end else if (ready_pick < 25) begin
                stall_left = $urandom_range(0, 2);
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_random_bytes(int n);
        repeat (n) msg_q.push_back(8'($urandom));
    endfunction

    function automatic void trim_message(int keep);
        while (msg_q.size() > keep) void'(msg_q.pop_back());
    endfunction

    function automatic void push_header(bit teid);
        logic [gtpsteer_pkg::BYTE_W-1:0] first;
        first = 8'($urandom);
        first[gtpsteer_pkg::TEID_FLAG_BIT] = teid;
        msg_q.push_back(first);
        push_random_bytes(int'(teid ? gtpsteer_pkg::LONG_HDR : gtpsteer_pkg::SHORT_HDR) - 1);
    endfunction

    // The spare upper nibble of the instance octet is always random.
    function automatic void push_ie_head(logic [gtpsteer_pkg::BYTE_W-1:0] t, int len,
                                         logic [gtpsteer_pkg::NIB_W-1:0] inst);
        msg_q.push_back(t);
        msg_q.push_back(8'(len >> 8));
        msg_q.push_back(8'(len));
        msg_q.push_back({4'($urandom), inst});
    endfunction

    // fill_digit < 0 leaves out the filler; wide allows the nibbles A to E.
    function automatic void push_imsi_ie(int nbytes, int fill_digit, bit wide,
                                         logic [gtpsteer_pkg::NIB_W-1:0] inst);
        logic [gtpsteer_pkg::NIB_W-1:0]  nib;
        logic [gtpsteer_pkg::BYTE_W-1:0] two_digits;
        int                              d;
        push_ie_head(gtpsteer_pkg::IMSI_TYPE, nbytes, inst);
        for (int k = 0; k < nbytes; k++) begin
            two_digits = '0;
            for (int h = 0; h < 2; h++) begin
                d = 2 * k + h;
                if (d == fill_digit) nib = gtpsteer_pkg::NIB_FILLER;
                else if (fill_digit >= 0 && d > fill_digit) nib = 4'($urandom);
                else if (wide) nib = 4'($urandom_range(0, 14));
                else nib = 4'($urandom_range(0, 9));
                two_digits[4*h +: 4] = nib;
            end
            msg_q.push_back(two_digits);
        end
    endfunction

    function automatic void push_other_ie();
        int                              r;
        logic [gtpsteer_pkg::BYTE_W-1:0] t;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            push_ie_head(gtpsteer_pkg::IMSI_TYPE, $urandom_range(1, 6),
                         4'($urandom_range(1, 15)));
            push_random_bytes(32'(msg_q[msg_q.size()-2]));
        end else if (r < 25) begin
            push_ie_head((r < 20) ? gtpsteer_pkg::IMSI_TYPE : 8'($urandom), 0, 4'($urandom));
        end else if (r < 28) begin
            // Length far beyond the message: everything after is swallowed.
            push_ie_head(8'($urandom), $urandom_range(256, 65535), 4'($urandom));
            push_random_bytes($urandom_range(0, 4));
        end else begin
            t = 8'($urandom);
            if (t == gtpsteer_pkg::IMSI_TYPE) t = t + 1'b1;
            push_ie_head(t, $urandom_range(0, 6), 4'($urandom));
            push_random_bytes(32'(msg_q[msg_q.size()-2]));
        end
    endfunction

    function automatic void build_random_message();
        int r;
        int nbytes;
        int fill;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            push_random_bytes($urandom_range(1, 30));
        end else if (r < 14) begin
            push_header($urandom_range(0, 1));
            trim_message($urandom_range(1, msg_q.size() - 1));
        end else begin
            push_header($urandom_range(0, 1));
            repeat ($urandom_range(0, 3)) push_other_ie();
            if ($urandom_range(0, 9) != 0) begin
                nbytes = ($urandom_range(0, 99) < 70) ? 8 : $urandom_range(1, 11);
                r = $urandom_range(0, 99);
                if (r < 50) fill = 15;
                else if (r < 65) fill = -1;
                else fill = $urandom_range(0, 2 * nbytes - 1);
                push_imsi_ie(nbytes, fill, $urandom_range(0, 9) == 0,
                             gtpsteer_pkg::INSTANCE_ZERO);
            end
            repeat ($urandom_range(0, 2)) push_other_ie();
            if ($urandom_range(0, 9) == 0) trim_message($urandom_range(1, msg_q.size()));
        end
    endfunction

    // Sends the message held in msg_q, one item per handshake.
    task automatic send_message(input bit no_gaps);
        int gap;
        bit calm;
        calm = no_gaps || ($urandom_range(0, 99) < 30);
        for (int k = 0; k < msg_q.size(); k++) begin
            gap = calm ? 0 : pick_gap();
            if (gap > 0) begin
                msg.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            msg.valid <= 1'b1;
            msg.data_byte <= msg_q[k];
            msg.last_byte <= (k == msg_q.size() - 1);
            do @(posedge i_clk); while (!msg.ready);
        end
        msg_q.delete();
    endtask

    // Holds the input back until every owed result has come, then lets the
    // block settle.
    task automatic wait_drain();
        msg.valid <= 1'b0;
        @(posedge i_clk);
        for (int w = 0; w < DRAIN_LIMIT && tracker.expected_steering.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.expected_steering.size() != 0) begin
            tracker.note_failure($sformatf("%0d results never arrived",
                                           tracker.expected_steering.size()));
            tracker.expected_steering.delete();
        end
    endtask

    task automatic write_workers(input logic [gtpsteer_pkg::WORKER_W-1:0] n);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= gtpsteer_pkg::REG_WORKER_COUNT;
        pwdata <= {24'($urandom), n};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.workers = n;
    endtask

    initial begin : stimulus
        int                                sent;
        logic [gtpsteer_pkg::WORKER_W-1:0] workers;
        i_rst_n <= 1'b0;
        msg.valid <= 1'b0;
        msg.data_byte <= '0;
        msg.last_byte <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset worker count of one: every shard index is zero.
        msg_q.push_back(8'h48);
        send_message(1'b0);
        push_header(1'b1);
        push_imsi_ie(8, 15, 1'b0, gtpsteer_pkg::INSTANCE_ZERO);
        send_message(1'b0);
        wait_drain();
        write_workers(8'd255);

        // Message ending inside a long header, then one that is header only.
        push_header(1'b1);
        trim_message(10);
        send_message(1'b0);
        push_header(1'b0);
        send_message(1'b0);
        // Plain fifteen-digit IMSI, then digits A to E without filler.
        push_header(1'b0);
        push_imsi_ie(8, 15, 1'b0, gtpsteer_pkg::INSTANCE_ZERO);
        send_message(1'b0);
        push_header(1'b0);
        push_imsi_ie(8, -1, 1'b1, gtpsteer_pkg::INSTANCE_ZERO);
        send_message(1'b0);
        // IMSI longer than the hashed part.
        push_header(1'b1);
        push_imsi_ie(11, -1, 1'b0, gtpsteer_pkg::INSTANCE_ZERO);
        send_message(1'b0);
        // Zero-length elements, an IMSI among them, are stepped over.
        push_header(1'b0);
        push_ie_head(gtpsteer_pkg::IMSI_TYPE, 0, gtpsteer_pkg::INSTANCE_ZERO);
        push_ie_head(8'h57, 0, 4'd3);
        push_imsi_ie(5, 9, 1'b0, gtpsteer_pkg::INSTANCE_ZERO);
        send_message(1'b0);
        // An IMSI with a non-zero instance does not count.
        push_header(1'b0);
        push_imsi_ie(8, 15, 1'b0, 4'd1);
        push_imsi_ie(8, 15, 1'b0, gtpsteer_pkg::INSTANCE_ZERO);
        send_message(1'b0);
        // Once found, a second IMSI and the trailing bytes change nothing.
        push_header(1'b0);
        push_imsi_ie(6, -1, 1'b0, gtpsteer_pkg::INSTANCE_ZERO);
        push_imsi_ie(8, 15, 1'b0, gtpsteer_pkg::INSTANCE_ZERO);
        push_random_bytes(5);
        send_message(1'b0);
        // A long IMSI cut short after its hashed part never commits.
        push_header(1'b1);
        push_imsi_ie(11, 15, 1'b0, gtpsteer_pkg::INSTANCE_ZERO);
        trim_message(msg_q.size() - 2);
        send_message(1'b0);
        // Filler in the very first nibble leaves the seed as the hash.
        push_header(1'b0);
        push_imsi_ie(4, 0, 1'b0, gtpsteer_pkg::INSTANCE_ZERO);
        send_message(1'b0);
        // IMSI with a huge length, and a message cut inside the length field.
        push_header(1'b0);
        push_ie_head(gtpsteer_pkg::IMSI_TYPE, 16'h8003, gtpsteer_pkg::INSTANCE_ZERO);
        push_random_bytes(3);
        send_message(1'b0);
        push_header(1'b0);
        push_ie_head(8'h4c, 2, gtpsteer_pkg::INSTANCE_ZERO);
        trim_message(msg_q.size() - 2);
        send_message(1'b0);
        wait_drain();
        write_workers(8'd0);

        // A worker count of zero acts as one.
        push_header(1'b0);
        push_imsi_ie(8, 15, 1'b0, gtpsteer_pkg::INSTANCE_ZERO);
        send_message(1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drain();
            case (p)
                0: workers = 8'd1;
                1: workers = 8'd255;
                2: workers = 8'd128;
                default: workers = 8'($urandom_range(2, 254));
            endcase
            write_workers(workers);
            sent = 0;
            while (sent < RANDOM_BYTES / RANDOM_PHASES) begin
                build_random_message();
                sent += msg_q.size();
                send_message(1'b0);
                if ($urandom_range(0, 24) == 0) wait_drain();
            end
        end

        wait_drain();
        if (tracker.fail_count == 0) begin
            $display("gtpv2c_imsi_shard_steering_core_tb OK");
        end else begin
            $display("gtpv2c_imsi_shard_steering_core_tb NOT OK");
        end
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("gtpv2c_imsi_shard_steering_core_tb NOT OK");
        $finish;
    end

endmodule
